// File: rtl/krs_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// krs_pkg
// Types and codes shared by the keyed record stack and its cells.
// ============================================================================
package krs_pkg;

    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;
    localparam logic [1:0] OP_QUERY  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    localparam int MARK_W = 16;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] key;
        logic [15:0]        value;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] average;
        logic [6:0]  entries;
    } rsp_t;

    typedef struct packed {
        logic signed [31:0] key;
        logic [15:0]        mark;
    } record_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_SHIFT
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t mode;
    } cell_ctrl_t;

endpackage

// File: rtl/krs_cell.sv
`timescale 1ns / 1ps
// ============================================================================
// krs_cell
// One stack slot: holds a record, takes the one above on a push and the one
// below on a shift toward the top.
// ============================================================================
module krs_cell (
    input  logic                clk,
    input  krs_pkg::cell_ctrl_t ctrl,
    input  krs_pkg::record_t    above,
    input  krs_pkg::record_t    below,
    output krs_pkg::record_t    rec
);

    krs_pkg::record_t rec_reg;
    krs_pkg::record_t rec_next;

    always_comb
    begin
        unique case (ctrl.mode)
            krs_pkg::CELL_PUSH:  rec_next = above;
            krs_pkg::CELL_SHIFT: rec_next = below;
            default:             rec_next = rec_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign rec = rec_reg;

endmodule

// File: rtl/krs_div.sv
`timescale 1ns / 1ps
// ============================================================================
// krs_div
// Restoring divider, one quotient bit per cycle. The quotient is known to
// fit in sixteen bits, so sixteen steps suffice.
// ============================================================================
module krs_div #(
    parameter int CW = 7
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [krs_pkg::MARK_W+CW-1:0]   dividend,
    input  logic [CW-1:0]                   divisor,
    output logic                            done,
    output logic [krs_pkg::MARK_W-1:0]      quotient
);

    localparam int SW = krs_pkg::MARK_W + CW;

    logic          busy_reg;
    logic          busy_next;
    logic          done_reg;
    logic          done_next;
    logic [3:0]    step_reg;
    logic [3:0]    step_next;
    logic [SW-1:0] rem_reg;
    logic [SW-1:0] rem_next;
    logic [SW-1:0] dv_reg;
    logic [SW-1:0] dv_next;
    logic [krs_pkg::MARK_W-1:0] q_reg;
    logic [krs_pkg::MARK_W-1:0] q_next;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dv_next   = dv_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = 4'd0;
            rem_next  = dividend;
            dv_next   = SW'(divisor) << (krs_pkg::MARK_W - 1);
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= dv_reg)
            begin
                rem_next = rem_reg - dv_reg;
                q_next   = {q_reg[krs_pkg::MARK_W-2:0], 1'b1};
            end
            else
            begin
                q_next = {q_reg[krs_pkg::MARK_W-2:0], 1'b0};
            end
            dv_next   = dv_reg >> 1;
            step_next = step_reg + 4'd1;
            if (step_reg == 4'd15)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 4'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dv_reg  <= dv_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// File: rtl/keyed_record_stack.sv
`timescale 1ns / 1ps
// Push and pop need no scan; the response is registered the cycle after the request.
// Update on a non-empty stack rotates the whole ring of DEPTH cells once per request.
// Query on a non-empty stack rotates the ring and then runs a 16-step divider.
// One request is in work at a time; the response register frees the next request.
// Reset (rst_n, asynchronous) empties the stack; record contents are left as they are.
// ============================================================================
// keyed_record_stack
// Bounded stack of keyed records held in a ring of cells, with search by key
// and mean of all marks.
// ============================================================================
module keyed_record_stack #(
    parameter int DEPTH = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  krs_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output krs_pkg::rsp_t  rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int TW = $clog2(DEPTH);
    localparam int SW = krs_pkg::MARK_W + CW;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]    state_reg;
    logic [1:0]    state_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [TW-1:0] step_reg;
    logic [TW-1:0] step_next;
    logic          hit_reg;
    logic          hit_next;
    logic [SW-1:0] sum_reg;
    logic [SW-1:0] sum_next;
    logic [1:0]    op_reg;
    logic [1:0]    op_next;
    logic signed [31:0] key_reg;
    logic signed [31:0] key_next;
    logic [15:0]   val_reg;
    logic [15:0]   val_next;
    logic [1:0]    res_status_reg;
    logic [1:0]    res_status_next;
    logic [15:0]   res_avg_reg;
    logic [15:0]   res_avg_next;
    logic          rsp_valid_reg;
    logic          rsp_valid_next;
    krs_pkg::rsp_t rsp_reg;
    krs_pkg::rsp_t rsp_next;

    logic          req_accept;
    logic          out_free;
    logic          res_load;
    logic          in_range;
    logic          match;
    logic          scan_last;
    logic          div_start;
    logic          div_done;
    logic [15:0]   div_q;

    krs_pkg::cell_ctrl_t cell_ctrl;
    krs_pkg::record_t    push_rec;
    krs_pkg::record_t    wrap_rec;
    krs_pkg::record_t    recs [DEPTH];

    // Ring of cells: cell 0 is the top of the stack, and on a shift it wraps to the bottom.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        krs_pkg::record_t above;
        krs_pkg::record_t below;
        if (i == 0)
        begin : g_top
            assign above = push_rec;
        end
        else
        begin : g_mid
            assign above = recs[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_bot
            assign below = wrap_rec;
        end
        else
        begin : g_up
            assign below = recs[i+1];
        end
        krs_cell u_cell (
            .clk   (clk),
            .ctrl  (cell_ctrl),
            .above (above),
            .below (below),
            .rec   (recs[i])
        );
    end

    krs_div #(
        .CW (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign req_stall  = (state_reg != S_IDLE) || !out_free;
    assign req_accept = req_valid && !req_stall;

    assign push_rec.key  = req.key;
    assign push_rec.mark = req.value;

    // The record passing the top at this step of the rotation is step_reg
    // places below the top; only those under the count are live.
    assign in_range  = CW'(step_reg) < count_reg;
    assign scan_last = step_reg == TW'(DEPTH - 1);
    assign match     = (state_reg == S_SCAN) && (op_reg == krs_pkg::OP_UPDATE) && !hit_reg
                       && in_range && (recs[0].key == key_reg);

    always_comb
    begin
        wrap_rec = recs[0];
        if (match)
        begin
            wrap_rec.mark = val_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        step_next       = step_reg;
        hit_next        = hit_reg;
        sum_next        = sum_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        res_status_next = res_status_reg;
        res_avg_next    = res_avg_reg;
        res_load        = 1'b0;
        div_start       = 1'b0;
        cell_ctrl.mode  = krs_pkg::CELL_HOLD;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    op_next         = req.operation;
                    key_next        = req.key;
                    val_next        = req.value;
                    step_next       = '0;
                    hit_next        = 1'b0;
                    sum_next        = '0;
                    res_status_next = krs_pkg::ST_OK;
                    res_avg_next    = 16'd0;
                    unique case (req.operation)
                        krs_pkg::OP_PUSH:
                        begin
                            res_load = 1'b1;
                            if (count_reg == CW'(DEPTH))
                            begin
                                res_status_next = krs_pkg::ST_FULL;
                            end
                            else
                            begin
                                cell_ctrl.mode = krs_pkg::CELL_PUSH;
                                count_next     = count_reg + CW'(1);
                            end
                        end
                        krs_pkg::OP_POP:
                        begin
                            res_load = 1'b1;
                            if (count_reg == '0)
                            begin
                                res_status_next = krs_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cell_ctrl.mode = krs_pkg::CELL_SHIFT;
                                count_next     = count_reg - CW'(1);
                            end
                        end
                        krs_pkg::OP_UPDATE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_load        = 1'b1;
                                res_status_next = krs_pkg::ST_NOT_FOUND;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                res_load        = 1'b1;
                                res_status_next = krs_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                cell_ctrl.mode = krs_pkg::CELL_SHIFT;
                step_next      = step_reg + TW'(1);
                if (match)
                begin
                    hit_next = 1'b1;
                end
                if (in_range)
                begin
                    sum_next = sum_reg + SW'(recs[0].mark);
                end
                if (scan_last)
                begin
                    if (op_reg == krs_pkg::OP_UPDATE)
                    begin
                        res_status_next = (hit_reg || match) ? krs_pkg::ST_OK
                                                             : krs_pkg::ST_NOT_FOUND;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    res_avg_next = div_q;
                    state_next   = S_DONE;
                end
            end
            default:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        rsp_next         = rsp_reg;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;
        if (res_load)
        begin
            rsp_valid_next   = 1'b1;
            rsp_next.status  = res_status_next;
            rsp_next.average = res_avg_next;
            rsp_next.entries = 7'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            hit_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            hit_reg       <= hit_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg        <= sum_next;
        op_reg         <= op_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        res_status_reg <= res_status_next;
        res_avg_reg    <= res_avg_next;
        rsp_reg        <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("record count exceeds stack depth");

    a_count_only_on_request: assert property (@(posedge clk) disable iff (!rst_n)
        !req_accept |=> $stable(count_reg))
        else $error("record count changed without a request");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide phase");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (!rsp_valid_reg || !rsp_stall))
        else $error("response overwritten while stalled");
`endif

endmodule
